@@ src/pi_controller_antiwindup_rate_limit_core_defines.svh @@
// Assertion macros shared by the checker of the brake controller core.
`ifndef PI_CONTROLLER_ANTIWINDUP_RATE_LIMIT_CORE_DEFINES_SVH
`define PI_CONTROLLER_ANTIWINDUP_RATE_LIMIT_CORE_DEFINES_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define PIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked at the next rising edge.
`define PIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked on a later rising edge than the antecedent.
`define PIC_ASSERT_AFTER3(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (ante) |=> ##2 (cons)) else $error(msg);

`endif

@@ src/pic_pkg.sv @@
// Types and constants of the PI brake controller core.
package pic_pkg;

  // Input item and result item
  typedef struct packed {
    logic signed [15:0] decel_request;
    logic signed [15:0] decel_measured;
    logic [15:0]        time_step;
  } in_item_t;

  typedef struct packed {
    logic [14:0] brake_command;
    logic        rate_limited;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [15:0] kp_gain;
    logic [15:0] ki_gain;
    logic [14:0] integ_ceiling;
    logic [14:0] output_min;
    logic [14:0] output_max;
    logic [23:0] rate_limit;
  } cfg_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_CEILING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT    = 3'd5;

  localparam logic [15:0] KP_GAIN_RST       = 16'd1024;
  localparam logic [15:0] KI_GAIN_RST       = 16'd205;
  localparam logic [14:0] INTEG_CEILING_RST = 15'd12800;
  localparam logic [14:0] OUTPUT_MIN_RST    = 15'd0;
  localparam logic [14:0] OUTPUT_MAX_RST    = 15'd25600;
  localparam logic [23:0] RATE_LIMIT_RST    = 24'd25600;

  // Operand selections of the shared multiplier
  localparam logic [1:0] MUL_KI_DT    = 2'd0;
  localparam logic [1:0] MUL_PROD_ERR = 2'd1;
  localparam logic [1:0] MUL_KP_ERR   = 2'd2;
  localparam logic [1:0] MUL_RL_DT    = 2'd3;

  // Ways of finishing an item
  localparam logic [1:0] FIN_NORMAL = 2'd0;
  localparam logic [1:0] FIN_CLEAR  = 2'd1;
  localparam logic [1:0] FIN_HOLD   = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load_item;
    logic       mul_en;
    logic [1:0] mul_op;
    logic       upd_integ;
    logic       upd_outv;
    logic       fin_en;
    logic [1:0] fin;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic target_nonpos;
    logic step_zero;
    logic out_free;
  } dp_status_t;

endpackage

@@ src/pic_cfg_regs.sv @@
// Configuration register file of the PI brake controller core.
module pic_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pic_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pic_pkg::CFG_DATA_W-1:0] cfg_data,
  output pic_pkg::cfg_t                  cfg
);
  import pic_pkg::*;

  // Writes are always taken; cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  // Each write lands in the register its index names; other indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain       <= KP_GAIN_RST;
      cfg.ki_gain       <= KI_GAIN_RST;
      cfg.integ_ceiling <= INTEG_CEILING_RST;
      cfg.output_min    <= OUTPUT_MIN_RST;
      cfg.output_max    <= OUTPUT_MAX_RST;
      cfg.rate_limit    <= RATE_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KP_GAIN:       cfg.kp_gain       <= cfg_data[15:0];
        REG_KI_GAIN:       cfg.ki_gain       <= cfg_data[15:0];
        REG_INTEG_CEILING: cfg.integ_ceiling <= cfg_data[14:0];
        REG_OUTPUT_MIN:    cfg.output_min    <= cfg_data[14:0];
        REG_OUTPUT_MAX:    cfg.output_max    <= cfg_data[14:0];
        REG_RATE_LIMIT:    cfg.rate_limit    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

endmodule

@@ src/pic_ctrl.sv @@
// Sequencing state machine of the PI brake controller core.
module pic_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pic_pkg::dp_status_t status,
  output pic_pkg::dp_cmd_t    cmd
);
  import pic_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KD   = 3'd1;
  localparam logic [2:0] S_ERR  = 3'd2;
  localparam logic [2:0] S_KP   = 3'd3;
  localparam logic [2:0] S_RL   = 3'd4;
  localparam logic [2:0] S_LIM  = 3'd5;
  localparam logic [2:0] S_CLR  = 3'd6;
  localparam logic [2:0] S_HOLD = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and the commands issued in each state.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_KD;
        end
      end
      S_KD: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_KI_DT;
        if (status.target_nonpos) begin
          state_next = S_CLR;
        end else if (status.step_zero) begin
          state_next = S_HOLD;
        end else begin
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_PROD_ERR;
        state_next = S_KP;
      end
      S_KP: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_op    = MUL_KP_ERR;
        cmd.upd_integ = 1'b1;
        state_next    = S_RL;
      end
      S_RL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_op   = MUL_RL_DT;
        cmd.upd_outv = 1'b1;
        state_next   = S_LIM;
      end
      S_LIM: begin
        cmd.fin = FIN_NORMAL;
        if (status.out_free) begin
          cmd.fin_en = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.fin = FIN_CLEAR;
        if (status.out_free) begin
          cmd.fin_en = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_HOLD: begin
        cmd.fin = FIN_HOLD;
        if (status.out_free) begin
          cmd.fin_en = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/pic_datapath.sv @@
// Arithmetic datapath of the PI brake controller core around one shared multiplier.
module pic_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pic_pkg::cfg_t       cfg,
  input  pic_pkg::in_item_t   in_data,
  input  pic_pkg::dp_cmd_t    cmd,
  output pic_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output pic_pkg::out_item_t  out_data
);
  import pic_pkg::*;

  in_item_t            item;
  logic signed [16:0]  err;
  logic signed [32:0]  mul_a;
  logic signed [17:0]  mul_b;
  logic signed [50:0]  prod;
  logic [31:0]         integrator;
  logic [14:0]         outv;
  logic [14:0]         last_output;

  logic signed [38:0]  inc;
  logic signed [39:0]  isum;
  logic signed [39:0]  imax_ext;
  logic signed [39:0]  iclamp;
  logic signed [41:0]  kp_term;
  logic signed [42:0]  rsum;
  logic signed [26:0]  raw;
  logic signed [26:0]  rclamp;
  logic [23:0]         md;
  logic signed [25:0]  md_s;
  logic signed [25:0]  prev_s;
  logic signed [25:0]  delta;
  logic signed [25:0]  lim_v;
  logic signed [25:0]  fclamp;
  logic                limited;

  // Item register; the error is formed once on the way in.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
      err  <= {in_data.decel_request[15], in_data.decel_request}
            - {in_data.decel_measured[15], in_data.decel_measured};
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.mul_op)
      MUL_KI_DT: begin
        mul_a = $signed({17'd0, cfg.ki_gain});
        mul_b = $signed({2'b00, item.time_step});
      end
      MUL_PROD_ERR: begin
        mul_a = $signed({1'b0, prod[31:0]});
        mul_b = {err[16], err};
      end
      MUL_KP_ERR: begin
        mul_a = $signed({17'd0, cfg.kp_gain});
        mul_b = {err[16], err};
      end
      MUL_RL_DT: begin
        mul_a = $signed({9'd0, cfg.rate_limit});
        mul_b = $signed({2'b00, item.time_step});
      end
      default: begin
        mul_a = $signed({17'd0, cfg.ki_gain});
        mul_b = $signed({2'b00, item.time_step});
      end
    endcase
  end

  // Product register of the shared multiplier.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Integrator step: floor of ki*err*dt to 24 fraction bits, then clamp.
  always_comb begin
    inc      = $signed(prod[50:12]);
    isum     = $signed({8'd0, integrator}) + {inc[38], inc};
    imax_ext = $signed({9'd0, cfg.integ_ceiling, 16'd0});
    iclamp   = isum;
    if (iclamp < 40'sd0) begin
      iclamp = 40'sd0;
    end
    if (iclamp > imax_ext) begin
      iclamp = imax_ext;
    end
  end

  // Raw output: kp*err plus integrator, floored to Q7.8 and clamped.
  always_comb begin
    kp_term = $signed({prod[33:0], 8'd0});
    rsum    = {kp_term[41], kp_term} + $signed({11'd0, integrator});
    raw     = rsum[42:16];
    rclamp  = raw;
    if (rclamp < $signed({12'd0, cfg.output_min})) begin
      rclamp = $signed({12'd0, cfg.output_min});
    end
    if (rclamp > $signed({12'd0, cfg.output_max})) begin
      rclamp = $signed({12'd0, cfg.output_max});
    end
  end

  // Rate limiter against the previous command, then the final clamp.
  always_comb begin
    md      = prod[39:16];
    md_s    = $signed({2'b00, md});
    prev_s  = $signed({11'd0, last_output});
    delta   = $signed({11'd0, outv}) - prev_s;
    limited = 1'b0;
    lim_v   = $signed({11'd0, outv});
    if (delta > md_s) begin
      lim_v   = prev_s + md_s;
      limited = 1'b1;
    end else if (delta < -md_s) begin
      lim_v   = prev_s - md_s;
      limited = 1'b1;
    end
    fclamp = lim_v;
    if (fclamp < $signed({11'd0, cfg.output_min})) begin
      fclamp = $signed({11'd0, cfg.output_min});
    end
    if (fclamp > $signed({11'd0, cfg.output_max})) begin
      fclamp = $signed({11'd0, cfg.output_max});
    end
  end

  // Clamped raw output waits here for the rate limiter.
  always_ff @(posedge clk) begin
    if (cmd.upd_outv) begin
      outv <= rclamp[14:0];
    end
  end

  // Controller state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator  <= '0;
      last_output <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.upd_integ) begin
        integrator <= iclamp[31:0];
      end
      if (cmd.fin_en) begin
        out_valid <= 1'b1;
        case (cmd.fin)
          FIN_NORMAL: begin
            last_output            <= fclamp[14:0];
            out_data.brake_command <= fclamp[14:0];
            out_data.rate_limited  <= limited;
          end
          FIN_CLEAR: begin
            integrator             <= '0;
            last_output            <= '0;
            out_data.brake_command <= '0;
            out_data.rate_limited  <= 1'b0;
          end
          FIN_HOLD: begin
            out_data.brake_command <= last_output;
            out_data.rate_limited  <= 1'b0;
          end
          default: begin
            out_data.brake_command <= last_output;
            out_data.rate_limited  <= 1'b0;
          end
        endcase
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Status back to the controller.
  assign status.target_nonpos = item.decel_request[15] || (item.decel_request == 16'sd0);
  assign status.step_zero     = (item.time_step == 16'd0);
  assign status.out_free      = !out_valid || out_ready;

endmodule

@@ src/pi_controller_antiwindup_rate_limit_core.sv @@
// PI brake controller with integrator anti-windup and output rate limiting.
// One item at a time is processed: a normal item goes from its accept
// cycle through four products on the single shared 33 x 18 multiplier and
// a rate-limit step to its registered result, and the block takes no new
// item before then; that last step waits while a result is still stalled.
// An item with a non-positive target or a zero time step finishes after its
// first product. A finished result is held in an output register, and
// the next item is accepted while it waits. Configuration writes
// must be made only while no item is in progress.
module pi_controller_antiwindup_rate_limit_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pic_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pic_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pic_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pic_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pic_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration registers.
  pic_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer.
  pic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  pic_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ src/pic_checker.sv @@
// Port-level checker of the PI brake controller core and its bind.
`include "pi_controller_antiwindup_rate_limit_core_defines.svh"

module pic_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input pic_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input pic_pkg::out_item_t out_data
);
  import pic_pkg::*;

  logic stalled;
  logic in_take;
  logic tgt_nonpos;
  logic clear_take;
  logic hold_take;
  logic zero_result;

  // Conditions on the ports that the properties refer to.
  assign stalled     = out_valid && !out_ready;
  assign in_take     = in_valid && in_ready && !out_valid;
  assign tgt_nonpos  = in_data.decel_request[15] || (in_data.decel_request == 16'sd0);
  assign clear_take  = in_take && tgt_nonpos;
  assign hold_take   = in_take && !tgt_nonpos && (in_data.time_step == 16'd0);
  assign zero_result = out_valid && (out_data.brake_command == 15'd0) && !out_data.rate_limited;

  // A stalled result holds its value.
  `PIC_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_data), "result changed while stalled")

  // Only one item is in progress at a time.
  `PIC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken too early")

  // A non-positive target gives a zero command when its item finishes.
  `PIC_ASSERT_AFTER3(a_clear_out, clear_take, zero_result, "non-positive target gave a command")

  // A zero time step never reports rate limiting.
  `PIC_ASSERT_AFTER3(a_hold_flag, hold_take, out_valid && !out_data.rate_limited, "hold was flagged")

endmodule

bind pi_controller_antiwindup_rate_limit_core pic_checker u_pic_checker (.*);
